// ----- rtl/key_index_map_allocator_core_macros.svh -----
// Assertion macros for the key/index map allocator.
// Used by key_index_map_allocator_core; expects clk and rst_n in scope.
`ifndef KEY_INDEX_MAP_ALLOCATOR_CORE_MACROS_SVH
`define KEY_INDEX_MAP_ALLOCATOR_CORE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define KIMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define KIMA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/kima_pkg.sv -----
// Package for the key/index map allocator: sizes, codes, sequencer states
// and the bucket hash. No dependencies.
package kima_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int BUCKET_COUNT  = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int LINK_W        = SLOT_W + 1;
    localparam int BKT_W         = $clog2(BUCKET_COUNT);
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        OP_KEY_GET_OR_NEW = 2'd0,
        OP_KEY_GET        = 2'd1,
        OP_IDX_GET_OR_NEW = 2'd2,
        OP_BIND_KEY       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_CREATED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BELOW_MIN = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_HRD, S_HCHK, S_SRD, S_SCHK, S_FOUND, S_MISS, S_CRD, S_CHD,
        S_CREATE, S_UHRD, S_UHCHK, S_UWAIT, S_UCHK, S_LINK, S_LHRD, S_LHCHK,
        S_EMIT
    } state_t;

    // XOR-fold of the four bytes, reduced to the bucket count (a power of two).
    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] v);
        logic [7:0] f;
        f = v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
        return f[BKT_W-1:0];
    endfunction

endpackage

// ----- rtl/key_index_map_allocator_core.sv -----
// Key/index map allocator: hashed key and index chains over slot memories.
// An index below first_index goes straight to the result; else the bucket head
// is read and chain entries compared in turn. A create by key reads the index
// bucket head first; a bind links into the new key chain, a rebind first unlinks
// from the old. One request at a time, accepted only while the sequencer is idle.
// Reset clears control state and bucket-head flags at once; no clearing pass.
module key_index_map_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] value,
    input  logic [31:0] bound_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] entry_index,
    output logic [31:0] entry_key,
    output logic        key_known
);

`include "key_index_map_allocator_core_macros.svh"

    localparam int SW = kima_pkg::SLOT_W;
    localparam int LW = kima_pkg::LINK_W;
    localparam int BW = kima_pkg::BKT_W;

    // Control and result registers.
    kima_pkg::state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [31:0] val_reg, val_next, bk_reg, bk_next;
    logic [BW-1:0] hb_reg, hb_next;
    logic [SW-1:0] addr_reg, addr_next, slot_reg, slot_next;
    logic [LW-1:0] ihd_reg, ihd_next, khd_reg, khd_next, slink_reg, slink_next;
    logic [2:0]  res_st_reg, res_st_next;
    logic [31:0] res_idx_reg, res_idx_next, res_key_reg, res_key_next;
    logic        res_kn_reg, res_kn_next;
    logic [LW-1:0] used_reg, used_next;
    logic [31:0] nfi_reg, nfi_next, first_reg;
    logic        out_valid_reg;
    logic [2:0]  out_st_reg;
    logic [31:0] out_idx_reg, out_key_reg;
    logic        out_kn_reg;

    // Bucket-head flags cleared by reset.
    logic [kima_pkg::BUCKET_COUNT-1:0]  khv_reg, ihv_reg;

    // Memories and their ports.
    logic [31:0]   key_mem   [kima_pkg::TABLE_ENTRIES];
    logic [31:0]   idx_mem   [kima_pkg::TABLE_ENTRIES];
    logic [LW-1:0] klink_mem [kima_pkg::TABLE_ENTRIES];
    logic [LW-1:0] ilink_mem [kima_pkg::TABLE_ENTRIES];
    logic          kv_mem    [kima_pkg::TABLE_ENTRIES];
    logic [LW-1:0] khead_mem [kima_pkg::BUCKET_COUNT];
    logic [LW-1:0] ihead_mem [kima_pkg::BUCKET_COUNT];

    logic [31:0]   key_rd, idx_rd;
    logic          kv_rd;
    logic [LW-1:0] klink_rd, ilink_rd, khead_rd, ihead_rd, khead_q, ihead_q;
    logic          key_we, idx_we, klink_we, ilink_we, khead_we, ihead_we, kv_we, kv_wd;
    logic [SW-1:0] key_wa, idx_wa, klink_wa, ilink_wa, kv_wa;
    logic [BW-1:0] khead_wa, ihead_wa;
    logic [31:0]   key_wd, idx_wd;
    logic [LW-1:0] klink_wd, ilink_wd, khead_wd, ihead_wd;
    logic          is_key_op, match;
    logic [31:0]   new_idx;

    always_ff @(posedge clk)
    begin
        if (key_we) key_mem[key_wa] <= key_wd;
        key_rd <= key_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we) idx_mem[idx_wa] <= idx_wd;
        idx_rd <= idx_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (klink_we) klink_mem[klink_wa] <= klink_wd;
        klink_rd <= klink_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ilink_we) ilink_mem[ilink_wa] <= ilink_wd;
        ilink_rd <= ilink_mem[addr_reg];
    end

    // Key-bound flag per slot; written when the slot is created, so every
    // slot reached through a chain holds a defined flag.
    always_ff @(posedge clk)
    begin
        if (kv_we) kv_mem[kv_wa] <= kv_wd;
        kv_rd <= kv_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (khead_we) khead_mem[khead_wa] <= khead_wd;
        khead_rd <= khead_mem[hb_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ihead_we) ihead_mem[ihead_wa] <= ihead_wd;
        ihead_rd <= ihead_mem[hb_reg];
    end

    // A bucket never written reads as an empty chain.
    assign khead_q   = khv_reg[hb_reg] ? khead_rd : kima_pkg::NO_SLOT;
    assign ihead_q   = ihv_reg[hb_reg] ? ihead_rd : kima_pkg::NO_SLOT;
    assign is_key_op = (op_reg == kima_pkg::OP_KEY_GET_OR_NEW) ||
                       (op_reg == kima_pkg::OP_KEY_GET);
    assign match     = is_key_op ? (kv_rd && key_rd == val_reg)
                                 : (idx_rd == val_reg);
    assign new_idx   = (op_reg == kima_pkg::OP_KEY_GET_OR_NEW) ? nfi_reg : val_reg;

    // Sequencer: next state, memory writes and result fields.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; val_next = val_reg; bk_next = bk_reg;
        hb_next = hb_reg; addr_next = addr_reg; slot_next = slot_reg;
        ihd_next = ihd_reg; khd_next = khd_reg; slink_next = slink_reg;
        res_st_next = res_st_reg; res_idx_next = res_idx_reg;
        res_key_next = res_key_reg; res_kn_next = res_kn_reg;
        used_next = used_reg; nfi_next = nfi_reg;
        key_we = 1'b0; key_wa = slot_reg; key_wd = bk_reg;
        idx_we = 1'b0; idx_wa = used_reg[SW-1:0]; idx_wd = new_idx;
        klink_we = 1'b0; klink_wa = slot_reg; klink_wd = khead_q;
        ilink_we = 1'b0; ilink_wa = used_reg[SW-1:0]; ilink_wd = ihd_reg;
        khead_we = 1'b0; khead_wa = hb_reg; khead_wd = {1'b0, slot_reg};
        ihead_we = 1'b0; ihead_wa = kima_pkg::bucket_of(new_idx);
        ihead_wd = used_reg;
        kv_we = 1'b0; kv_wa = slot_reg; kv_wd = 1'b1;
        unique case (state_reg)
            kima_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    val_next = value;
                    bk_next  = bound_key;
                    hb_next  = kima_pkg::bucket_of(value);
                    if (operation[1] && value < first_reg)
                    begin
                        res_st_next  = kima_pkg::ST_BELOW_MIN;
                        res_idx_next = '0; res_key_next = '0; res_kn_next = 1'b0;
                        state_next   = kima_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = kima_pkg::S_HRD;
                    end
                end
            end
            kima_pkg::S_HRD: state_next = kima_pkg::S_HCHK;
            kima_pkg::S_HCHK:
            begin
                khd_next = khead_q;
                ihd_next = ihead_q;
                if ((is_key_op ? khead_q[SW] : ihead_q[SW]))
                begin
                    state_next = kima_pkg::S_MISS;
                end
                else
                begin
                    addr_next  = is_key_op ? khead_q[SW-1:0] : ihead_q[SW-1:0];
                    state_next = kima_pkg::S_SRD;
                end
            end
            kima_pkg::S_SRD: state_next = kima_pkg::S_SCHK;
            // Compare one chain entry, then follow its link.
            kima_pkg::S_SCHK:
            begin
                if (match)
                begin
                    state_next = kima_pkg::S_FOUND;
                end
                else if ((is_key_op ? klink_rd[SW] : ilink_rd[SW]))
                begin
                    state_next = kima_pkg::S_MISS;
                end
                else
                begin
                    addr_next  = is_key_op ? klink_rd[SW-1:0] : ilink_rd[SW-1:0];
                    state_next = kima_pkg::S_SRD;
                end
            end
            kima_pkg::S_FOUND:
            begin
                res_st_next = kima_pkg::ST_FOUND;
                slot_next   = addr_reg;
                if (op_reg == kima_pkg::OP_BIND_KEY)
                begin
                    if (kv_rd)
                    begin
                        hb_next    = kima_pkg::bucket_of(key_rd);
                        slink_next = klink_rd;
                        state_next = kima_pkg::S_UHRD;
                    end
                    else
                    begin
                        state_next = kima_pkg::S_LINK;
                    end
                end
                else
                begin
                    res_idx_next = idx_rd;
                    res_key_next = kv_rd ? key_rd : '0;
                    res_kn_next  = kv_rd;
                    state_next   = kima_pkg::S_EMIT;
                end
            end
            kima_pkg::S_MISS:
            begin
                res_idx_next = '0; res_key_next = '0; res_kn_next = 1'b0;
                if (op_reg == kima_pkg::OP_KEY_GET)
                begin
                    res_st_next = kima_pkg::ST_NOT_FOUND;
                    state_next  = kima_pkg::S_EMIT;
                end
                else if (used_reg[SW])
                begin
                    res_st_next = kima_pkg::ST_FULL;
                    state_next  = kima_pkg::S_EMIT;
                end
                else if (op_reg == kima_pkg::OP_KEY_GET_OR_NEW)
                begin
                    hb_next    = kima_pkg::bucket_of(nfi_reg);
                    state_next = kima_pkg::S_CRD;
                end
                else
                begin
                    state_next = kima_pkg::S_CREATE;
                end
            end
            kima_pkg::S_CRD: state_next = kima_pkg::S_CHD;
            kima_pkg::S_CHD:
            begin
                ihd_next   = ihead_q;
                state_next = kima_pkg::S_CREATE;
            end
            // Take the next slot and put it at the head of its index chain.
            kima_pkg::S_CREATE:
            begin
                idx_we      = 1'b1;
                ilink_we    = 1'b1;
                ihead_we    = 1'b1;
                kv_we       = 1'b1;
                kv_wa       = used_reg[SW-1:0];
                slot_next   = used_reg[SW-1:0];
                used_next   = used_reg + 1'b1;
                res_st_next = kima_pkg::ST_CREATED;
                if (op_reg == kima_pkg::OP_KEY_GET_OR_NEW)
                begin
                    // Key is bound at once under the head read at lookup time.
                    kv_wd    = 1'b1;
                    key_we   = 1'b1; key_wa = used_reg[SW-1:0]; key_wd = val_reg;
                    klink_we = 1'b1; klink_wa = used_reg[SW-1:0]; klink_wd = khd_reg;
                    khead_we = 1'b1; khead_wa = kima_pkg::bucket_of(val_reg);
                    khead_wd = used_reg;
                    nfi_next = nfi_reg + 1'b1;
                    res_idx_next = nfi_reg; res_key_next = val_reg; res_kn_next = 1'b1;
                    state_next = kima_pkg::S_EMIT;
                end
                else
                begin
                    kv_wd = 1'b0;
                    if (nfi_reg <= val_reg) nfi_next = val_reg + 1'b1;
                    res_idx_next = val_reg; res_key_next = '0; res_kn_next = 1'b0;
                    state_next = (op_reg == kima_pkg::OP_BIND_KEY) ? kima_pkg::S_LINK
                                                                   : kima_pkg::S_EMIT;
                end
            end
            // Unlink a rebound slot from its old key chain.
            kima_pkg::S_UHRD: state_next = kima_pkg::S_UHCHK;
            kima_pkg::S_UHCHK:
            begin
                if (khead_q == {1'b0, slot_reg})
                begin
                    khead_we = 1'b1; khead_wd = slink_reg;
                    state_next = kima_pkg::S_LINK;
                end
                else if (khead_q[SW])
                begin
                    state_next = kima_pkg::S_LINK;
                end
                else
                begin
                    addr_next  = khead_q[SW-1:0];
                    state_next = kima_pkg::S_UWAIT;
                end
            end
            kima_pkg::S_UWAIT: state_next = kima_pkg::S_UCHK;
            kima_pkg::S_UCHK:
            begin
                if (klink_rd == {1'b0, slot_reg})
                begin
                    klink_we = 1'b1; klink_wa = addr_reg; klink_wd = slink_reg;
                    state_next = kima_pkg::S_LINK;
                end
                else if (klink_rd[SW])
                begin
                    state_next = kima_pkg::S_LINK;
                end
                else
                begin
                    addr_next  = klink_rd[SW-1:0];
                    state_next = kima_pkg::S_UWAIT;
                end
            end
            // Link the slot at the head of the new key's chain.
            kima_pkg::S_LINK:
            begin
                hb_next    = kima_pkg::bucket_of(bk_reg);
                state_next = kima_pkg::S_LHRD;
            end
            kima_pkg::S_LHRD: state_next = kima_pkg::S_LHCHK;
            kima_pkg::S_LHCHK:
            begin
                klink_we = 1'b1;
                khead_we = 1'b1;
                key_we   = 1'b1;
                kv_we    = 1'b1;
                res_idx_next = val_reg; res_key_next = bk_reg; res_kn_next = 1'b1;
                state_next = kima_pkg::S_EMIT;
            end
            kima_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready) state_next = kima_pkg::S_IDLE;
            end
            default: state_next = kima_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kima_pkg::S_IDLE;
            used_reg      <= '0;
            first_reg     <= 32'd1;
            nfi_reg       <= 32'd1;
            khv_reg       <= '0;
            ihv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_wr_en)
            begin
                first_reg <= cfg_wr_data;
                nfi_reg   <= cfg_wr_data;
            end
            else
            begin
                nfi_reg <= nfi_next;
            end
            if (khead_we) khv_reg[khead_wa] <= 1'b1;
            if (ihead_we) ihv_reg[ihead_wa] <= 1'b1;
            if (state_reg == kima_pkg::S_EMIT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; val_reg <= val_next; bk_reg <= bk_next;
        hb_reg <= hb_next; addr_reg <= addr_next; slot_reg <= slot_next;
        ihd_reg <= ihd_next; khd_reg <= khd_next; slink_reg <= slink_next;
        res_st_reg <= res_st_next; res_idx_reg <= res_idx_next;
        res_key_reg <= res_key_next; res_kn_reg <= res_kn_next;
        if (state_reg == kima_pkg::S_EMIT && (!out_valid_reg || out_ready))
        begin
            out_st_reg  <= res_st_reg;
            out_idx_reg <= res_idx_reg;
            out_key_reg <= res_key_reg;
            out_kn_reg  <= res_kn_reg;
        end
    end

    assign in_ready    = (state_reg == kima_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign entry_index = out_idx_reg;
    assign entry_key   = out_key_reg;
    assign key_known   = out_kn_reg;

    // Checks on the sequencer.
    `KIMA_ASSERT(a_used_only_create, (used_reg != $past(used_reg)) |-> ($past(state_reg) == kima_pkg::S_CREATE), "slot count changed outside create")
    `KIMA_NEVER(a_create_when_full, (state_reg == kima_pkg::S_CREATE) && used_reg[SW], "slot created in a full table")
    `KIMA_NEVER(a_walk_unused_slot, (state_reg == kima_pkg::S_SCHK) && ({1'b0, addr_reg} >= used_reg), "chain walk reached an unused slot")
    `KIMA_ASSERT(a_emit_holds, (state_reg == kima_pkg::S_EMIT && out_valid_reg && !out_ready) |=> (state_reg == kima_pkg::S_EMIT), "result dropped while output stalled")

endmodule

// ----- sim/testbench.sv -----
// Testbench for key_index_map_allocator_core: directed and random requests
// checked against a behavioral table model. Depends on kima_pkg and the core.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int MAX_SLOTS   = 256;
    localparam int NUM_BKT     = 64;
    localparam int NONE        = 256;

    typedef struct packed {
        kima_pkg::op_t op;
        logic [31:0]   value;
        logic [31:0]   bound_key;
    } request_t;

    typedef struct packed {
        kima_pkg::status_t st;
        logic [31:0]       index;
        logic [31:0]       key;
        logic              known;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [31:0] value = '0;
    logic [31:0] bound_key = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] entry_index;
    logic [31:0] entry_key;
    logic        key_known;

    key_index_map_allocator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .value(value), .bound_key(bound_key),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .entry_index(entry_index),
        .entry_key(entry_key), .key_known(key_known)
    );

    always #1 clk = ~clk;

    // Shadow of the table.
    logic [31:0] tbl_first;
    logic [31:0] tbl_next;
    int          tbl_used;
    logic        sl_valid [MAX_SLOTS];
    logic        sl_kvalid [MAX_SLOTS];
    logic [31:0] sl_key [MAX_SLOTS];
    logic [31:0] sl_index [MAX_SLOTS];
    int          key_head [NUM_BKT];
    int          idx_head [NUM_BKT];
    int          key_link [MAX_SLOTS];
    int          idx_link [MAX_SLOTS];

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       recv_hold = 0;
    logic     sender_pause = 1'b0;
    int       cycles = 0;

    function automatic int fold_bucket(logic [31:0] v);
        logic [7:0] f;
        f = v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
        return f % NUM_BKT;
    endfunction

    function automatic int search_key(logic [31:0] k);
        int s;
        s = key_head[fold_bucket(k)];
        for (int n = 0; n < MAX_SLOTS && s < NONE; n++) begin
            if (sl_valid[s] && sl_kvalid[s] && sl_key[s] == k)
                return s;
            s = key_link[s];
        end
        return NONE;
    endfunction

    function automatic int search_index(logic [31:0] ix);
        int s;
        s = idx_head[fold_bucket(ix)];
        for (int n = 0; n < MAX_SLOTS && s < NONE; n++) begin
            if (sl_valid[s] && sl_index[s] == ix)
                return s;
            s = idx_link[s];
        end
        return NONE;
    endfunction

    function automatic int take_slot(logic [31:0] ix);
        int s;
        int b;
        s = tbl_used;
        b = fold_bucket(ix);
        tbl_used++;
        sl_valid[s] = 1'b1;
        sl_index[s] = ix;
        sl_kvalid[s] = 1'b0;
        sl_key[s] = '0;
        idx_link[s] = idx_head[b];
        idx_head[b] = s;
        return s;
    endfunction

    // Attach a key, first removing the slot from its old key chain.
    function automatic void attach_key(int s, logic [31:0] k);
        int b;
        int p;
        if (sl_kvalid[s]) begin
            b = fold_bucket(sl_key[s]);
            p = key_head[b];
            if (p == s)
                key_head[b] = key_link[s];
            else
                for (int n = 0; n < MAX_SLOTS && p < NONE; n++) begin
                    if (key_link[p] == s) begin
                        key_link[p] = key_link[s];
                        break;
                    end
                    p = key_link[p];
                end
        end
        b = fold_bucket(k);
        sl_key[s] = k;
        sl_kvalid[s] = 1'b1;
        key_link[s] = key_head[b];
        key_head[b] = s;
    endfunction

    function automatic answer_t make_answer(kima_pkg::status_t st, int s);
        answer_t a;
        a = '0;
        a.st = st;
        if (s < NONE) begin
            a.index = sl_index[s];
            a.key = sl_kvalid[s] ? sl_key[s] : 32'd0;
            a.known = sl_kvalid[s];
        end
        return a;
    endfunction

    function automatic answer_t apply_request(request_t r);
        int s;
        kima_pkg::status_t st;
        if (r.op == kima_pkg::OP_KEY_GET_OR_NEW || r.op == kima_pkg::OP_KEY_GET) begin
            s = search_key(r.value);
            if (s < NONE)
                return make_answer(kima_pkg::ST_FOUND, s);
            if (r.op == kima_pkg::OP_KEY_GET)
                return make_answer(kima_pkg::ST_NOT_FOUND, NONE);
            if (tbl_used >= MAX_SLOTS)
                return make_answer(kima_pkg::ST_FULL, NONE);
            s = take_slot(tbl_next);
            tbl_next = tbl_next + 32'd1;
            attach_key(s, r.value);
            return make_answer(kima_pkg::ST_CREATED, s);
        end
        if (r.value < tbl_first)
            return make_answer(kima_pkg::ST_BELOW_MIN, NONE);
        s = search_index(r.value);
        st = kima_pkg::ST_FOUND;
        if (s >= NONE) begin
            if (tbl_used >= MAX_SLOTS)
                return make_answer(kima_pkg::ST_FULL, NONE);
            s = take_slot(r.value);
            if (tbl_next <= r.value)
                tbl_next = r.value + 32'd1;
            st = kima_pkg::ST_CREATED;
        end
        if (r.op == kima_pkg::OP_BIND_KEY)
            attach_key(s, r.bound_key);
        return make_answer(st, s);
    endfunction

    function automatic void clear_table();
        tbl_first = 32'd1;
        tbl_next = 32'd1;
        tbl_used = 0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            sl_valid[i] = 1'b0;
            sl_kvalid[i] = 1'b0;
            sl_key[i] = '0;
            sl_index[i] = '0;
            key_link[i] = 0;
            idx_link[i] = 0;
        end
        for (int i = 0; i < NUM_BKT; i++) begin
            key_head[i] = NONE;
            idx_head[i] = NONE;
        end
    endfunction

    // Driver: present the oldest pending request and predict it on acceptance.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_answers.push_back(apply_request(pending_requests.pop_front()));
            end
            if (in_valid && !in_ready) begin
                // hold the request steady
            end else if (pending_requests.size() > 0 && !sender_pause
                         && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                operation <= pending_requests[0].op;
                value <= pending_requests[0].value;
                bound_key <= pending_requests[0].bound_key;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with an optional long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        answer_t exp_a;
        if (rst_n && out_valid && out_ready) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status=%0d index=%h", status, entry_index);
            end else begin
                exp_a = expected_answers.pop_front();
                if (status !== exp_a.st || entry_index !== exp_a.index
                    || entry_key !== exp_a.key || key_known !== exp_a.known) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp st=%0d idx=%h key=%h kn=%0b, %s",
                                 exp_a.st, exp_a.index, exp_a.key, exp_a.known,
                                 $sformatf("got st=%0d idx=%h key=%h kn=%0b",
                                           status, entry_index, entry_key, key_known));
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_request(kima_pkg::op_t op, logic [31:0] v, logic [31:0] bk);
        request_t r;
        r.op = op;
        r.value = v;
        r.bound_key = bk;
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_first_index(logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tbl_first = v;
        tbl_next = v;
    endtask

    // Random requests: keys from a small pool so lookups hit and rebinds occur.
    task automatic add_random(int count, logic [31:0] base);
        logic [31:0] pool [8];
        logic [31:0] v;
        for (int i = 0; i < 8; i++)
            pool[i] = $urandom();
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: v = $urandom();
                1, 2, 3: v = pool[$urandom_range(7)];
                default: v = base + $urandom_range(40);
            endcase
            if ($urandom_range(3) == 0 && i % 2 == 0)
                v = base - $urandom_range(3);
            add_request(kima_pkg::op_t'($urandom_range(3)), v,
                        ($urandom_range(1) ? pool[$urandom_range(7)] : $urandom()));
        end
    endtask

    initial begin
        clear_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation, field extremes, rebinding, duplicates,
        // below-minimum indices and counter wrap.
        add_request(kima_pkg::OP_KEY_GET, 32'h0, 32'h0);
        add_request(kima_pkg::OP_KEY_GET_OR_NEW, 32'h0, 32'hFFFFFFFF);
        add_request(kima_pkg::OP_KEY_GET_OR_NEW, 32'hFFFFFFFF, 32'h0);
        add_request(kima_pkg::OP_KEY_GET, 32'hFFFFFFFF, 32'h0);
        add_request(kima_pkg::OP_IDX_GET_OR_NEW, 32'h0, 32'h0);
        add_request(kima_pkg::OP_IDX_GET_OR_NEW, 32'h1, 32'h0);
        add_request(kima_pkg::OP_IDX_GET_OR_NEW, 32'h10, 32'h0);
        add_request(kima_pkg::OP_BIND_KEY, 32'h10, 32'hA5A5A5A5);
        add_request(kima_pkg::OP_BIND_KEY, 32'h10, 32'h5A5A5A5A);
        add_request(kima_pkg::OP_KEY_GET, 32'hA5A5A5A5, 32'h0);
        add_request(kima_pkg::OP_KEY_GET, 32'h5A5A5A5A, 32'h0);
        add_request(kima_pkg::OP_BIND_KEY, 32'h20, 32'h5A5A5A5A);
        add_request(kima_pkg::OP_KEY_GET, 32'h5A5A5A5A, 32'h0);
        add_request(kima_pkg::OP_BIND_KEY, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_request(kima_pkg::OP_KEY_GET_OR_NEW, 32'h12345678, 32'h0);
        add_request(kima_pkg::OP_IDX_GET_OR_NEW, 32'h0, 32'h0);
        add_request(kima_pkg::OP_KEY_GET_OR_NEW, 32'h01010101, 32'h0);
        drain();

        // Phase one: first_index at its low extreme, sender idles less.
        write_first_index(32'h0);
        send_idle_pct = 26;
        recv_idle_pct = 55;
        add_random(60, 32'h0);
        // Long receiver hold-off while requests keep coming.
        recv_hold = 300;
        add_random(40, 32'h100);
        drain();

        // Phase two: near the top extreme, then mid value; roles reversed.
        write_first_index(32'hFFFFFFF0);
        send_idle_pct = 55;
        recv_idle_pct = 26;
        add_random(80, 32'hFFFFFFF0);
        // Sender pauses mid-stream until every result is in.
        repeat (100) @(posedge clk);
        sender_pause = 1'b1;
        while (in_valid || expected_answers.size() > 0)
            @(posedge clk);
        sender_pause = 1'b0;
        drain();
        write_first_index(32'h80000000);
        add_random(80, 32'h80000000);
        drain();

        // Phase three: no idling; fill the table and keep going past full.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_first_index(32'h1000);
        add_random(250, 32'h1000);
        drain();

        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
